>>> sv/rmvm_pkg.sv
// Shared types and constants for the running mean / variance / min-max block.
// Used by rmvm_engine and running_mean_variance_minmax. No dependencies.
package rmvm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int FRAC_BITS   = 16;

  // Widths of the fixed-point datapath
  localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;  // Q16.16 mean
  localparam int DIFF_BITS = MEAN_BITS + 2;            // deviation with headroom
  localparam int ENG_BITS  = 64;                       // shared unit operand width
  localparam int VAR_BITS  = 48;
  localparam int SD_BITS   = 32;

  // Item opcodes
  localparam logic OPC_PUSH  = 1'b0;
  localparam logic OPC_CLEAR = 1'b1;

  // Operations of the shared iterative unit
  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_SQRT
  } eng_op_t;

  typedef struct packed {
    logic    start;
    eng_op_t op;
  } eng_cmd_t;

  // Item sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_MDIV,
    S_MUL,
    S_VSTART,
    S_VDIV,
    S_SQRT,
    S_FIN
  } seq_state_t;

endpackage

>>> sv/rmvm_engine.sv
// Shared iterative arithmetic unit: restoring divide, shift-add multiply and
// digit-by-digit square root, all on one 65-bit add/subtract. Uses rmvm_pkg.
module rmvm_engine
  import rmvm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  eng_cmd_t            cmd,
  input  logic [ENG_BITS-1:0] opa,
  input  logic [ENG_BITS-1:0] opb,
  output logic                done,
  output logic [ENG_BITS:0]   res_hi,
  output logic [ENG_BITS-1:0] res_lo,
  output logic [SD_BITS-1:0]  res_root
);

  localparam logic [5:0] LAST_LONG = 6'(ENG_BITS - 1);
  localparam logic [5:0] LAST_SQRT = 6'(ENG_BITS / 2 - 1);

  logic                busy;
  eng_op_t             op;
  logic [5:0]          cnt;
  logic [ENG_BITS:0]   r;
  logic [ENG_BITS-1:0] q;
  logic [ENG_BITS-1:0] dv;
  logic [SD_BITS-1:0]  root;

  logic [ENG_BITS:0]   r_next;
  logic [ENG_BITS-1:0] q_next;
  logic [SD_BITS-1:0]  root_next;
  logic [ENG_BITS:0]   add_a;
  logic [ENG_BITS:0]   add_b;
  logic                sub;
  logic [ENG_BITS+1:0] sum;
  logic                ge;
  logic                last;

  // Operand selection for the single adder
  always_comb begin
    add_a = r;
    add_b = '0;
    sub   = 1'b0;
    case (op)
      OP_DIV: begin
        add_a = {r[ENG_BITS-1:0], q[ENG_BITS-1]};
        add_b = {1'b0, dv};
        sub   = 1'b1;
      end
      OP_MUL: begin
        add_a = r;
        add_b = q[0] ? {1'b0, dv} : '0;
        sub   = 1'b0;
      end
      OP_SQRT: begin
        add_a = {r[ENG_BITS-2:0], q[ENG_BITS-1:ENG_BITS-2]};
        add_b = {{(ENG_BITS - SD_BITS - 1){1'b0}}, root, 2'b01};
        sub   = 1'b1;
      end
      default: begin
        add_a = r;
        add_b = '0;
        sub   = 1'b0;
      end
    endcase
  end

  // The shared add/subtract; top bit is the carry, i.e. "a >= b" on subtract
  assign sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {{(ENG_BITS + 1){1'b0}}, sub};
  assign ge  = sum[ENG_BITS+1];

  // Next step of each iteration
  always_comb begin
    r_next    = r;
    q_next    = q;
    root_next = root;
    case (op)
      OP_DIV: begin
        r_next = ge ? sum[ENG_BITS:0] : add_a;
        q_next = {q[ENG_BITS-2:0], ge};
      end
      OP_MUL: begin
        r_next = sum[ENG_BITS+1:1];
        q_next = {sum[0], q[ENG_BITS-1:1]};
      end
      OP_SQRT: begin
        r_next    = ge ? sum[ENG_BITS:0] : add_a;
        q_next    = {q[ENG_BITS-3:0], 2'b00};
        root_next = {root[SD_BITS-2:0], ge};
      end
      default: begin
        r_next = r;
      end
    endcase
  end

  assign last = (op == OP_SQRT) ? (cnt == LAST_SQRT) : (cnt == LAST_LONG);

  // Completion flag, registered together with the final step
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && last;
    end
  end

  // Iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      op   <= OP_DIV;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      op   <= cmd.op;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r    <= '0;
      q    <= opa;
      dv   <= opb;
      root <= '0;
    end else if (busy) begin
      r    <= r_next;
      q    <= q_next;
      root <= root_next;
    end
  end

  assign res_hi   = r;
  assign res_lo   = q;
  assign res_root = root;

endmodule

>>> sv/running_mean_variance_minmax.sv
// Top level of the running statistics block: item sequencer and statistics
// registers around the shared unit rmvm_engine. Uses rmvm_pkg.

// Each item pushes one signed sample (Welford update of count, mean and
// squared-deviation sum, plus min and max) or clears the statistics, and
// returns one result with count, Q16.16 mean, Q32.16 variance, Q16.16
// standard deviation, min, max and a count-saturated flag. All arithmetic
// runs through one iterative unit, one step per cycle. A normal push goes
// from acceptance to the result register through the mean divide, the
// deviation multiply, a state that starts the variance step, the variance
// divide, the square root and a state that finishes; a push on a full
// count skips the mean divide and the deviation multiply, and a clear or a
// first sample also skips the variance divide. One item is worked on at a
// time; the next is accepted at the earliest in the cycle in which the
// result is in the output register, and later while a waiting result is
// stalled.
module running_mean_variance_minmax
  import rmvm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COUNT_BITS-1:0]         sample_count,
  output logic signed [MEAN_BITS-1:0]   mean_value,
  output logic [VAR_BITS-1:0]           variance_value,
  output logic [SD_BITS-1:0]            std_deviation,
  output logic signed [SAMPLE_BITS-1:0] minimum_value,
  output logic signed [SAMPLE_BITS-1:0] maximum_value,
  output logic                          count_full
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  seq_state_t state, state_next;

  // Statistics
  logic [COUNT_BITS-1:0]         count_reg;
  logic signed [MEAN_BITS-1:0]   mean_reg;
  logic [ENG_BITS-1:0]           sq_dev_sum;
  logic signed [SAMPLE_BITS-1:0] min_reg;
  logic signed [SAMPLE_BITS-1:0] max_reg;

  // Per-item working registers
  logic signed [DIFF_BITS-1:0]   xq;
  logic signed [DIFF_BITS-1:0]   dev;
  logic [VAR_BITS-1:0]           var_reg;

  logic                          accept;
  logic                          out_free;
  logic                          full;
  logic signed [DIFF_BITS-1:0]   xq_in;
  logic signed [DIFF_BITS-1:0]   d_in;
  logic [DIFF_BITS-1:0]          d_in_mag;
  logic [DIFF_BITS-1:0]          dev_mag;
  logic signed [DIFF_BITS-1:0]   quot;
  logic signed [DIFF_BITS-1:0]   new_mean;
  logic signed [DIFF_BITS-1:0]   err;
  logic [DIFF_BITS-1:0]          err_mag;
  logic [ENG_BITS-1:0]           term;
  logic [ENG_BITS:0]             sum_wide;
  logic [ENG_BITS-1:0]           sum_sat;
  logic [VAR_BITS-1:0]           var_clamp;

  eng_cmd_t                      cmd;
  logic [ENG_BITS-1:0]           opa;
  logic [ENG_BITS-1:0]           opb;
  logic                          eng_done;
  logic [ENG_BITS:0]             res_hi;
  logic [ENG_BITS-1:0]           res_lo;
  logic [SD_BITS-1:0]            res_root;

  rmvm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .opa      (opa),
    .opb      (opb),
    .done     (eng_done),
    .res_hi   (res_hi),
    .res_lo   (res_lo),
    .res_root (res_root)
  );

  assign full     = (count_reg == COUNT_MAX);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Deviation of the incoming sample from the current mean
  assign xq_in    = DIFF_BITS'(sample) <<< FRAC_BITS;
  assign d_in     = xq_in - DIFF_BITS'(mean_reg);
  assign d_in_mag = d_in[DIFF_BITS-1] ? DIFF_BITS'(-d_in) : d_in;
  assign dev_mag  = dev[DIFF_BITS-1] ? DIFF_BITS'(-dev) : dev;

  // Mean update from the divider quotient, truncated toward zero
  assign quot     = dev[DIFF_BITS-1] ? -$signed(res_lo[DIFF_BITS-1:0])
                                     : $signed(res_lo[DIFF_BITS-1:0]);
  assign new_mean = DIFF_BITS'(mean_reg) + quot;
  assign err      = xq - new_mean;
  assign err_mag  = err[DIFF_BITS-1] ? DIFF_BITS'(-err) : err;

  // Product shifted down by the fraction bits, saturating, then added
  assign term     = (res_hi[ENG_BITS:FRAC_BITS] != '0) ? '1
                    : {res_hi[FRAC_BITS-1:0], res_lo[ENG_BITS-1:FRAC_BITS]};
  assign sum_wide = {1'b0, sq_dev_sum} + {1'b0, term};
  assign sum_sat  = sum_wide[ENG_BITS] ? '1 : sum_wide[ENG_BITS-1:0];

  assign var_clamp = (res_lo[ENG_BITS-1:VAR_BITS] != '0) ? '1 : res_lo[VAR_BITS-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OPC_PUSH && !full && count_reg != '0) begin
            state_next = S_MDIV;
          end else begin
            state_next = S_VSTART;
          end
        end
      end
      S_MDIV:   if (eng_done) state_next = S_MUL;
      S_MUL:    if (eng_done) state_next = S_VSTART;
      S_VSTART: state_next = (count_reg > COUNT_BITS'(1)) ? S_VDIV : S_SQRT;
      S_VDIV:   if (eng_done) state_next = S_SQRT;
      S_SQRT:   if (eng_done) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Shared unit commands and operands
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_DIV;
    opa       = '0;
    opb       = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && opcode == OPC_PUSH && !full && count_reg != '0) begin
          cmd.start = 1'b1;
          cmd.op    = OP_DIV;
          opa       = ENG_BITS'(d_in_mag);
          opb       = ENG_BITS'(count_reg) + ENG_BITS'(1);
        end
      end
      S_MDIV: begin
        if (eng_done) begin
          cmd.start = 1'b1;
          cmd.op    = OP_MUL;
          opa       = ENG_BITS'(err_mag);
          opb       = ENG_BITS'(dev_mag);
        end
      end
      S_VSTART: begin
        cmd.start = 1'b1;
        if (count_reg > COUNT_BITS'(1)) begin
          cmd.op = OP_DIV;
          opa    = sq_dev_sum;
          opb    = ENG_BITS'(count_reg) - ENG_BITS'(1);
        end else begin
          cmd.op = OP_SQRT;
          opa    = '0;
        end
      end
      S_VDIV: begin
        if (eng_done) begin
          cmd.start = 1'b1;
          cmd.op    = OP_SQRT;
          opa       = {var_clamp, {(ENG_BITS - VAR_BITS){1'b0}}};
        end
      end
      S_MUL, S_SQRT, S_FIN: begin
        cmd.start = 1'b0;
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg  <= '0;
      mean_reg   <= '0;
      sq_dev_sum <= '0;
      min_reg    <= '0;
      max_reg    <= '0;
    end else begin
      if (state == S_IDLE && accept) begin
        if (opcode == OPC_CLEAR) begin
          count_reg  <= '0;
          mean_reg   <= '0;
          sq_dev_sum <= '0;
          min_reg    <= '0;
          max_reg    <= '0;
        end else if (!full) begin
          count_reg <= count_reg + COUNT_BITS'(1);
          if (count_reg == '0) begin
            mean_reg   <= MEAN_BITS'(xq_in);
            sq_dev_sum <= '0;
            min_reg    <= sample;
            max_reg    <= sample;
          end else begin
            if (sample < min_reg) min_reg <= sample;
            if (sample > max_reg) max_reg <= sample;
          end
        end
      end
      if (state == S_MDIV && eng_done) begin
        mean_reg <= MEAN_BITS'(new_mean);
      end
      if (state == S_MUL && eng_done) begin
        sq_dev_sum <= sum_sat;
      end
    end
  end

  // Per-item working values
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      xq  <= xq_in;
      dev <= d_in;
    end
    if (state == S_VSTART) begin
      var_reg <= '0;
    end else if (state == S_VDIV && eng_done) begin
      var_reg <= var_clamp;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      sample_count   <= count_reg;
      mean_value     <= mean_reg;
      variance_value <= var_reg;
      std_deviation  <= res_root;
      minimum_value  <= min_reg;
      maximum_value  <= max_reg;
      count_full     <= full;
    end
  end

endmodule
